[rtl/core/rht_pkg.sv]
// Shared constants, codes and types of the reference-counted handle table.
package rht_pkg;

    localparam int SLOTS    = 64;
    localparam int ID_BITS  = 32;
    localparam int REF_BITS = 16;
    localparam int TYPE_W   = 8;
    localparam int CMD_W    = 3;
    localparam int ST_W     = 3;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RETAIN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_IDS_OUT   = 3'd3;
    localparam logic [ST_W-1:0] ST_SATURATED = 3'd4;

    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    typedef struct packed {
        logic [ID_BITS-1:0]  ident;
        logic [TYPE_W-1:0]   kind;
        logic [REF_BITS-1:0] refs;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Outcome of one count update on a matched slot.
    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [REF_BITS-1:0] refs_new;
        logic [REF_BITS-1:0] refs_out;
        logic                freed;
        logic                write;
    } t_upd;

endpackage

[rtl/core/refcounted_handle_table.sv]
// Top level of the reference-counted handle table: sequencer, slot state and result word.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  command  | start in, busy out        | i_cmd, i_obj_type, i_obj_id
//  result   | o_done strobe, one cycle  | o_status, o_slot_index, o_result_id,
//           |                           | o_result_type, o_result_refs, o_was_freed,
//           |                           | o_live_count
//
// A command word is taken at an edge with start high and busy low; its result word
// is registered onto o_done from the last step. Lookups walk the slot RAM one
// slot a cycle through its registered read port, until the id is found or every
// slot has been read; a hit then moves on to the update step.
// Create walks the live bits until the first free slot.
// Rejected commands (full, ids out, bad code, id zero) answer straight from idle.
// Reset clears the live bits, counters and sequencer at once; no clearing pass.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module refcounted_handle_table
    import rht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [TYPE_W-1:0]   i_obj_type,
    input  logic [ID_BITS-1:0]  i_obj_id,
    output logic                o_done,
    output logic [ST_W-1:0]     o_status,
    output logic [IDX_W-1:0]    o_slot_index,
    output logic [ID_BITS-1:0]  o_result_id,
    output logic [TYPE_W-1:0]   o_result_type,
    output logic [REF_BITS-1:0] o_result_refs,
    output logic                o_was_freed,
    output logic [CNT_W-1:0]    o_live_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FREE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    // Sequencer and latched command.
    logic [1:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [ID_BITS-1:0]  r_key, n_key;
    logic [IDX_W-1:0]    r_addr, n_addr;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pidx, n_pidx;
    t_entry              r_hit, n_hit;
    logic [IDX_W-1:0]    r_hidx, n_hidx;

    // Slot state held in flops.
    logic [SLOTS-1:0]    r_live, n_live;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [ID_BITS-1:0]  r_next, n_next;

    // Result word.
    logic                r_done, n_done;
    logic [ST_W-1:0]     r_status, n_status;
    logic [IDX_W-1:0]    r_sidx, n_sidx;
    logic [ID_BITS-1:0]  r_rid, n_rid;
    logic [TYPE_W-1:0]   r_rtype, n_rtype;
    logic [REF_BITS-1:0] r_rrefs, n_rrefs;
    logic                r_freed, n_freed;
    logic [CNT_W-1:0]    r_lcnt, n_lcnt;

    // RAM port and shared unit.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    logic                unit_match;
    t_upd                unit_upd;
    logic                res_fail;
    logic [ST_W-1:0]     fail_code;
    logic                accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    rht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Compare against the slot whose data leaves the RAM; update the captured hit.
    rht_unit u_unit (
        .i_live  (r_live[r_pidx]),
        .i_ident (ram_rdata.ident),
        .i_key   (r_key),
        .i_cmd   (r_cmd),
        .i_refs  (r_hit.refs),
        .o_match (unit_match),
        .o_upd   (unit_upd)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_type    = r_type;
        n_key     = r_key;
        n_addr    = r_addr;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_hit     = r_hit;
        n_hidx    = r_hidx;
        n_live    = r_live;
        n_occ     = r_occ;
        n_next    = r_next;
        n_done    = 1'b0;
        n_status  = r_status;
        n_sidx    = r_sidx;
        n_rid     = r_rid;
        n_rtype   = r_rtype;
        n_rrefs   = r_rrefs;
        n_freed   = r_freed;
        n_lcnt    = r_lcnt;
        ram_we    = 1'b0;
        ram_waddr = r_hidx;
        ram_wdata.ident = r_hit.ident;
        ram_wdata.kind  = r_hit.kind;
        ram_wdata.refs  = unit_upd.refs_new;
        res_fail  = 1'b0;
        fail_code = ST_NOT_FOUND;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_cmd;
                    n_type = i_obj_type;
                    n_key  = i_obj_id;
                    n_addr = '0;
                    n_pend = 1'b0;
                    priority if (i_cmd == CMD_CREATE) begin
                        // Full is checked before the id counter.
                        priority if (r_occ >= CNT_W'(SLOTS)) begin
                            res_fail  = 1'b1;
                            fail_code = ST_FULL;
                        end else if (r_next == '0) begin
                            res_fail  = 1'b1;
                            fail_code = ST_IDS_OUT;
                        end else begin
                            n_state = S_FREE;
                        end
                    end else if (i_cmd > CMD_RELEASE || i_obj_id == '0) begin
                        res_fail  = 1'b1;
                        fail_code = ST_NOT_FOUND;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_FREE: begin
                // Advance over live slots; claim the first free one.
                if (!r_live[r_addr]) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_addr;
                    ram_wdata.ident = r_next;
                    ram_wdata.kind  = r_type;
                    ram_wdata.refs  = REF_BITS'(1);
                    n_live[r_addr]  = 1'b1;
                    n_occ           = r_occ + CNT_W'(1);
                    n_next          = r_next + ID_BITS'(1);
                    n_done          = 1'b1;
                    n_status        = ST_OK;
                    n_sidx          = r_addr;
                    n_rid           = r_next;
                    n_rtype         = r_type;
                    n_rrefs         = REF_BITS'(1);
                    n_freed         = 1'b0;
                    n_state         = S_IDLE;
                end else if (r_addr == LAST_SLOT) begin
                    res_fail  = 1'b1;
                    fail_code = ST_FULL;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_SCAN: begin
                // Read one slot a cycle; compare the one read last cycle.
                n_pend = 1'b1;
                n_pidx = r_addr;
                n_addr = r_addr + IDX_W'(1);
                if (r_pend) begin
                    if (unit_match) begin
                        n_hit   = ram_rdata;
                        n_hidx  = r_pidx;
                        n_state = S_UPD;
                    end else if (r_pidx == LAST_SLOT) begin
                        res_fail  = 1'b1;
                        fail_code = ST_NOT_FOUND;
                    end
                end
            end
            S_UPD: begin
                // Write back the new count, or drop the slot when freed.
                ram_we = unit_upd.write;
                if (unit_upd.freed) begin
                    n_live[r_hidx] = 1'b0;
                    if (r_occ != '0) begin
                        n_occ = r_occ - CNT_W'(1);
                    end
                end
                n_done   = 1'b1;
                n_status = unit_upd.status;
                n_sidx   = r_hidx;
                n_rid    = r_hit.ident;
                n_rtype  = r_hit.kind;
                n_rrefs  = unit_upd.refs_out;
                n_freed  = unit_upd.freed;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_fail) begin
            n_done   = 1'b1;
            n_status = fail_code;
            n_sidx   = '0;
            n_rid    = '0;
            n_rtype  = '0;
            n_rrefs  = '0;
            n_freed  = 1'b0;
            n_state  = S_IDLE;
        end
        if (n_done) begin
            n_lcnt = n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_live  <= '0;
            r_occ   <= '0;
            r_next  <= ID_BITS'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_live  <= n_live;
            r_occ   <= n_occ;
            r_next  <= n_next;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_type   <= n_type;
        r_key    <= n_key;
        r_addr   <= n_addr;
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_hidx   <= n_hidx;
        r_status <= n_status;
        r_sidx   <= n_sidx;
        r_rid    <= n_rid;
        r_rtype  <= n_rtype;
        r_rrefs  <= n_rrefs;
        r_freed  <= n_freed;
        r_lcnt   <= n_lcnt;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_index  = r_sidx;
    assign o_result_id   = r_rid;
    assign o_result_type = r_rtype;
    assign o_result_refs = r_rrefs;
    assign o_was_freed   = r_freed;
    assign o_live_count  = r_lcnt;

    // Occupancy counter tracks the live bits exactly.
    a_occ_matches_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_live) == 32'(r_occ))
        else $error("occupancy count differs from live slots");

    // A result word only follows an accepted command or sequencer work.
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result word without a command");

    // A freed slot reports ok with a zero count.
    a_freed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_was_freed) |-> (o_status == ST_OK && o_result_refs == '0))
        else $error("freed slot reports bad status or count");

    // A failed command carries no slot contents.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NOT_FOUND || o_status == ST_FULL ||
                    o_status == ST_IDS_OUT))
        |-> (o_result_id == '0 && o_slot_index == '0 && !o_was_freed))
        else $error("failed command reports slot contents");

endmodule

[rtl/core/rht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rht_unit.sv]
// Shared id compare and reference count update unit.
module rht_unit
    import rht_pkg::*;
(
    input  logic                i_live,
    input  logic [ID_BITS-1:0]  i_ident,
    input  logic [ID_BITS-1:0]  i_key,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [REF_BITS-1:0] i_refs,
    output logic                o_match,
    output t_upd                o_upd
);

    // Id zero never matches, and the live bit keeps a free slot's stale id from being hit.
    assign o_match = i_live && (i_key != '0) && (i_ident == i_key);

    always_comb begin
        o_upd.status   = ST_OK;
        o_upd.refs_new = i_refs;
        o_upd.refs_out = i_refs;
        o_upd.freed    = 1'b0;
        o_upd.write    = 1'b0;
        unique case (i_cmd)
            CMD_DESTROY: begin
                o_upd.freed    = 1'b1;
                o_upd.refs_out = '0;
            end
            CMD_RETAIN: begin
                if (i_refs == REF_MAX) begin
                    o_upd.status = ST_SATURATED;
                end else begin
                    o_upd.refs_new = i_refs + REF_BITS'(1);
                    o_upd.refs_out = i_refs + REF_BITS'(1);
                    o_upd.write    = 1'b1;
                end
            end
            CMD_RELEASE: begin
                // A zero count stays as it is.
                if (i_refs == REF_BITS'(1)) begin
                    o_upd.freed    = 1'b1;
                    o_upd.refs_new = '0;
                    o_upd.refs_out = '0;
                end else if (i_refs != '0) begin
                    o_upd.refs_new = i_refs - REF_BITS'(1);
                    o_upd.refs_out = i_refs - REF_BITS'(1);
                    o_upd.write    = 1'b1;
                end
            end
            default: begin
                // Find and codes never routed here report the count unchanged.
                o_upd.refs_out = i_refs;
            end
        endcase
    end

endmodule

[dv/rht_table_checker.sv]
// Checker for the handle table: predicts each result word and compares it with the block.
`timescale 1ns / 100ps

module rht_table_checker
    import rht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [TYPE_W-1:0]   i_obj_type,
    input  logic [ID_BITS-1:0]  i_obj_id,
    input  logic                i_done,
    input  logic [ST_W-1:0]     i_status,
    input  logic [IDX_W-1:0]    i_slot_index,
    input  logic [ID_BITS-1:0]  i_result_id,
    input  logic [TYPE_W-1:0]   i_result_type,
    input  logic [REF_BITS-1:0] i_result_refs,
    input  logic                i_was_freed,
    input  logic [CNT_W-1:0]    i_live_count,
    output int                  o_mismatches,
    output int                  o_pending
);

    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [IDX_W-1:0]    slot;
        logic [ID_BITS-1:0]  ident;
        logic [TYPE_W-1:0]   kind;
        logic [REF_BITS-1:0] refs;
        logic                freed;
        logic [CNT_W-1:0]    live;
    } t_reply;

    // Shadow copy of the slot table.
    logic [ID_BITS-1:0]  shadow_ident [SLOTS];
    logic [TYPE_W-1:0]   shadow_kind  [SLOTS];
    logic                shadow_live  [SLOTS];
    logic [REF_BITS-1:0] shadow_refs  [SLOTS];
    int                  occupied;
    logic [ID_BITS-1:0]  next_ident;

    t_reply replies_due [$];
    int     mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic void vacate_slot(int s);
        shadow_ident[s] = '0;
        shadow_kind[s]  = '0;
        shadow_live[s]  = 1'b0;
        shadow_refs[s]  = '0;
        if (occupied > 0)
            occupied--;
    endfunction

    // Run one command on the shadow table and return the word it must produce.
    function automatic t_reply apply_command(logic [CMD_W-1:0] cmd, logic [TYPE_W-1:0] kind,
                                             logic [ID_BITS-1:0] ident);
        t_reply r;
        int     hit;
        int     s;
        r        = '0;
        r.status = ST_NOT_FOUND;
        hit      = -1;
        if (cmd == CMD_CREATE) begin
            if (occupied >= SLOTS) begin
                r.status = ST_FULL;
            end else if (next_ident == '0) begin
                r.status = ST_IDS_OUT;
            end else begin
                for (s = 0; s < SLOTS; s++)
                    if (!shadow_live[s] && hit < 0)
                        hit = s;
                if (hit < 0) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_ident[hit] = next_ident;
                    shadow_kind[hit]  = kind;
                    shadow_live[hit]  = 1'b1;
                    shadow_refs[hit]  = REF_BITS'(1);
                    occupied++;
                    r.status   = ST_OK;
                    r.slot     = hit[IDX_W-1:0];
                    r.ident    = next_ident;
                    r.kind     = kind;
                    r.refs     = REF_BITS'(1);
                    next_ident = next_ident + 1'b1;
                end
            end
        end else if (cmd == CMD_DESTROY || cmd == CMD_FIND || cmd == CMD_RETAIN ||
                     cmd == CMD_RELEASE) begin
            // Id zero never matches, even against free slots.
            if (ident != '0)
                for (s = 0; s < SLOTS; s++)
                    if (hit < 0 && shadow_live[s] && shadow_ident[s] == ident)
                        hit = s;
            if (hit >= 0) begin
                r.status = ST_OK;
                r.slot   = hit[IDX_W-1:0];
                r.ident  = shadow_ident[hit];
                r.kind   = shadow_kind[hit];
                if (cmd == CMD_DESTROY) begin
                    vacate_slot(hit);
                    r.freed = 1'b1;
                end else if (cmd == CMD_RETAIN) begin
                    if (shadow_refs[hit] == REF_MAX)
                        r.status = ST_SATURATED;
                    else
                        shadow_refs[hit]++;
                    r.refs = shadow_refs[hit];
                end else if (cmd == CMD_RELEASE) begin
                    if (shadow_refs[hit] != '0) begin
                        shadow_refs[hit]--;
                        if (shadow_refs[hit] == '0) begin
                            vacate_slot(hit);
                            r.freed = 1'b1;
                        end
                    end
                    r.refs = r.freed ? '0 : shadow_refs[hit];
                end else begin
                    r.refs = shadow_refs[hit];
                end
            end
        end
        r.live = occupied[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                shadow_ident[s] = '0;
                shadow_kind[s]  = '0;
                shadow_live[s]  = 1'b0;
                shadow_refs[s]  = '0;
            end
            occupied   = 0;
            next_ident = ID_BITS'(1);
            replies_due.delete();
            o_pending <= 0;
        end else begin
            if (i_done) begin
                got = '{i_status, i_slot_index, i_result_id, i_result_type, i_result_refs,
                        i_was_freed, i_live_count};
                if (replies_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word with nothing expected", $time);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: result word mismatch (expected/actual)", $time,
                                     " status %0d/%0d", want.status, got.status,
                                     " slot %0d/%0d", want.slot, got.slot,
                                     " id %h/%h", want.ident, got.ident,
                                     " type %h/%h", want.kind, got.kind,
                                     " refs %0d/%0d", want.refs, got.refs,
                                     " freed %0d/%0d", want.freed, got.freed,
                                     " live %0d/%0d", want.live, got.live);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy)
                replies_due.push_back(apply_command(i_cmd, i_obj_type, i_obj_id));
            o_pending <= replies_due.size();
        end
    end

endmodule

[dv/tb_refcounted_handle_table.sv]
// Top of the handle table testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 100ps

module tb_refcounted_handle_table;
    import rht_pkg::*;

    // Highest command code the field can carry; codes above release are undefined.
    localparam logic [CMD_W-1:0] CMD_LAST = '1;

    // About 1250 random words plus a short directed part, each with its table walk and
    // often a random gap after it. Allow plenty.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 1250;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd;
    logic [TYPE_W-1:0]   i_obj_type;
    logic [ID_BITS-1:0]  i_obj_id;
    logic                o_done;
    logic [ST_W-1:0]     o_status;
    logic [IDX_W-1:0]    o_slot_index;
    logic [ID_BITS-1:0]  o_result_id;
    logic [TYPE_W-1:0]   o_result_type;
    logic [REF_BITS-1:0] o_result_refs;
    logic                o_was_freed;
    logic [CNT_W-1:0]    o_live_count;

    int mismatches;
    int pending;
    int cycles = 0;

    // Ids the block has reported as live, and a short history of freed ones.
    logic [ID_BITS-1:0] live_ids [$];
    logic [ID_BITS-1:0] dead_ids [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    refcounted_handle_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_obj_type    (i_obj_type),
        .i_obj_id      (i_obj_id),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_result_id   (o_result_id),
        .o_result_type (o_result_type),
        .o_result_refs (o_result_refs),
        .o_was_freed   (o_was_freed),
        .o_live_count  (o_live_count)
    );

    rht_table_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_obj_type    (i_obj_type),
        .i_obj_id      (i_obj_id),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_slot_index  (o_slot_index),
        .i_result_id   (o_result_id),
        .i_result_type (o_result_type),
        .i_result_refs (o_result_refs),
        .i_was_freed   (o_was_freed),
        .i_live_count  (o_live_count),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Hard stop in case the block hangs or drops a result word.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("refcounted_handle_table test failed");
            $finish;
        end
    end

    // Track which ids are live so most lookups hit. Sample at the falling edge, away
    // from the stimulus at the rising edge, so the pools never race with the sender.
    always @(negedge i_clk) begin
        int where;
        if (i_rst_n === 1'b1 && o_done === 1'b1 && o_status == ST_OK) begin
            where = -1;
            for (int k = 0; k < live_ids.size(); k++)
                if (where < 0 && live_ids[k] == o_result_id)
                    where = k;
            if (o_was_freed) begin
                if (where >= 0)
                    live_ids.delete(where);
                dead_ids.push_back(o_result_id);
                if (dead_ids.size() > 16)
                    void'(dead_ids.pop_front());
            end else if (where < 0 && o_result_id != '0) begin
                live_ids.push_back(o_result_id);
            end
        end
    end

    // Present one command word and hold it until the block takes it. Leave start high
    // so a following word can go out back to back.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TYPE_W-1:0] kind,
                             input logic [ID_BITS-1:0] ident);
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_obj_type <= kind;
        i_obj_id   <= ident;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // Drop start for the given gap; zero keeps the stream back to back.
    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the sender off until every issued word has answered.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // Mostly short gaps, now and then a long one that may cover a full table walk.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    function automatic logic [TYPE_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return TYPE_W'($urandom_range(0, 255));
    endfunction

    // Favor live ids; mix in freed ones, random words, zero and all ones.
    function automatic logic [ID_BITS-1:0] pick_ident();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72 && live_ids.size() > 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        if (r < 82 && dead_ids.size() > 0)
            return dead_ids[$urandom_range(0, dead_ids.size() - 1)];
        if (r < 92)
            return $urandom;
        if (r < 96)
            return '0;
        return '1;
    endfunction

    // Growing phases push toward a full table, shrinking phases free slots again.
    function automatic logic [CMD_W-1:0] pick_command(input logic grow);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            return CMD_W'($urandom_range(int'(CMD_RELEASE) + 1, int'(CMD_LAST)));
        if (grow) begin
            if (r < 50) return CMD_CREATE;
            if (r < 64) return CMD_RETAIN;
            if (r < 76) return CMD_RELEASE;
            if (r < 83) return CMD_DESTROY;
            return CMD_FIND;
        end
        if (r < 10) return CMD_CREATE;
        if (r < 24) return CMD_RETAIN;
        if (r < 56) return CMD_RELEASE;
        if (r < 78) return CMD_DESTROY;
        return CMD_FIND;
    endfunction

    initial begin
        int   sent;
        int   phase_len;
        logic grow;
        logic steady;

        start      <= 1'b0;
        i_cmd      <= CMD_FIND;
        i_obj_type <= '0;
        i_obj_id   <= '0;
        i_rst_n    <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        @(posedge i_clk);

        // Directed part. Ids come out in order from one, so the expected owners are known.
        send_word(CMD_FIND, '0, '0);             // id zero on an empty table
        pause(gap_length());
        send_word(CMD_RELEASE, '0, 1);           // nothing live yet
        pause(gap_length());
        send_word(CMD_CREATE, '0, '1);           // id 1, type none, slot 0
        send_word(CMD_CREATE, '1, '0);           // id 2, slot 1
        send_word(CMD_CREATE, 8'hA5, '0);        // id 3, slot 2
        pause(gap_length());
        send_word(CMD_FIND, '0, 2);
        send_word(CMD_RETAIN, '0, 2);
        send_word(CMD_RELEASE, '0, 2);
        send_word(CMD_RELEASE, '0, 2);           // final release frees slot 1
        pause(gap_length());
        send_word(CMD_FIND, '0, 2);              // freed id must miss
        send_word(CMD_CREATE, 8'h5A, '0);        // id 4 reuses the lowest free slot
        send_word(CMD_DESTROY, '0, '0);          // id zero never matches
        send_word(CMD_FIND, '1, '1);
        for (int c = int'(CMD_RELEASE) + 1; c <= int'(CMD_LAST); c++) begin
            send_word(CMD_W'(c), '1, 1);         // undefined codes answer not found
            pause(gap_length());
        end
        send_word(CMD_RETAIN, '0, 3);
        send_word(CMD_DESTROY, '0, 3);           // destroy with count above one
        send_word(CMD_RETAIN, '0, 3);
        send_word(CMD_FIND, '0, 1);
        drain();

        // Random part in alternating grow and shrink phases; some phases run with no gaps.
        sent = 0;
        grow = 1'b0;
        while (sent < RANDOM_WORDS) begin
            grow      = ~grow;
            phase_len = $urandom_range(80, 220);
            steady    = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
                send_word(pick_command(grow), pick_kind(), pick_ident());
                sent++;
                if (!steady)
                    pause(gap_length());
            end
            if ($urandom_range(0, 1) == 0)
                drain();
        end

        // Let the last words answer, then watch a little longer for strays.
        drain();
        repeat (SLOTS + 8) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("refcounted_handle_table test passed");
        else
            $display("refcounted_handle_table test failed");
        $finish;
    end

endmodule
